// ----- hw/rtl/dpda_pkg.sv -----
// Shared types and constants for the dual pulse debounce accumulator.
package dpda_pkg;

    localparam int unsigned STEP_W  = 3;
    localparam int unsigned TOTAL_W = 27;
    localparam int unsigned LPP_W   = 10;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 27;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LITERS_PER_PULSE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOT_PRESET       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLD_PRESET      = 2'd2;

    // Input command codes.
    localparam logic CMD_POLL = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef struct packed {
        logic command;
        logic hot_contact_low;
        logic cold_contact_low;
    } in_item_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] hot_total;
        logic [TOTAL_W-1:0] cold_total;
        logic               hot_pulse;
        logic               cold_pulse;
        logic               hot_closed;
        logic               cold_closed;
        logic               total_wrapped;
    } out_item_t;

    // Debounce state of one channel.
    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic              closed;
        logic              latched;
    } chan_t;

endpackage

// ----- hw/rtl/dual_pulse_debounce_accumulator.sv -----
// An accepted request's result is in the output register in the cycle after it is accepted.
// Throughput: one request per cycle while the output register is empty or draining; the channel
// update and the single add-and-wrap of each total fit between the state registers and the output register.
// A new request is taken while a result waits, provided the output register frees this cycle.
// Reset: debounce steps at the bottom, contacts open and released, totals zero,
// liters per pulse one, presets zero, no result pending.
module dual_pulse_debounce_accumulator #(
    parameter int unsigned DEBOUNCE_STEPS = 6,
    parameter int unsigned TOTAL_LIMIT    = 100000000
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  dpda_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output dpda_pkg::out_item_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dpda_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dpda_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dpda_pkg::*;

    // The top debounce step, and the limit widened so that a sum of a 27-bit total and a
    // 10-bit volume can be compared and reduced without losing the carry.
    localparam int unsigned SUM_W = 33;
    localparam logic [STEP_W-1:0] STEP_TOP  = STEP_W'(DEBOUNCE_STEPS);
    localparam logic [SUM_W-1:0]  LIMIT_EXT = SUM_W'(TOTAL_LIMIT);

    // Configuration registers.
    logic [LPP_W-1:0]   lpp_reg;
    logic [TOTAL_W-1:0] hot_preset_reg;
    logic [TOTAL_W-1:0] cold_preset_reg;

    // Channel state and running totals.
    chan_t              hot_reg, hot_next;
    chan_t              cold_reg, cold_next;
    logic [TOTAL_W-1:0] hot_sum_reg, hot_sum_next;
    logic [TOTAL_W-1:0] cold_sum_reg, cold_sum_next;

    // Output register.
    logic               out_valid_reg;
    out_item_t          out_data_reg, out_data_next;

    logic               in_accept;
    logic               hot_wrap, cold_wrap;
    logic               hot_pulse, cold_pulse;
    logic [TOTAL_W-1:0] hot_added, cold_added;

    // One poll of a channel's debounce: the step climbs while the contact is closed and
    // falls while it is open. The state only changes on a sample taken at the end step,
    // and the latch follows the state so that each closure is counted once.
    function automatic chan_t poll_chan(input chan_t cur, input logic contact);
        chan_t nxt;
        nxt = cur;
        if (contact)
        begin
            if (cur.step >= STEP_TOP)
                nxt.closed = 1'b1;
            else
                nxt.step = cur.step + STEP_W'(1);
        end
        else
        begin
            if (cur.step == '0)
                nxt.closed = 1'b0;
            else
                nxt.step = cur.step - STEP_W'(1);
        end
        nxt.latched = nxt.closed;
        return nxt;
    endfunction

    // Add one pulse's volume and wrap once at the limit; the top bit flags a wrap.
    function automatic logic [TOTAL_W:0] add_wrap(input logic [TOTAL_W-1:0] sum,
                                                  input logic [LPP_W-1:0]   lpp);
        logic [SUM_W-1:0] s;
        logic             wrapped;
        s = SUM_W'(sum) + SUM_W'(lpp);
        wrapped = (s >= LIMIT_EXT);
        if (wrapped)
            s = s - LIMIT_EXT;
        return {wrapped, s[TOTAL_W-1:0]};
    endfunction

    // The output register takes a new result whenever it is empty or being drained.
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign {hot_wrap, hot_added}   = add_wrap(hot_sum_reg, lpp_reg);
    assign {cold_wrap, cold_added} = add_wrap(cold_sum_reg, lpp_reg);

    always_comb
    begin
        hot_next      = hot_reg;
        cold_next     = cold_reg;
        hot_sum_next  = hot_sum_reg;
        cold_sum_next = cold_sum_reg;
        hot_pulse     = 1'b0;
        cold_pulse    = 1'b0;
        out_data_next = '0;

        if (in_data.command == CMD_LOAD)
        begin
            // A load replaces both totals and leaves the debounce state alone.
            hot_sum_next  = hot_preset_reg;
            cold_sum_next = cold_preset_reg;
        end
        else
        begin
            hot_next  = poll_chan(hot_reg, in_data.hot_contact_low);
            cold_next = poll_chan(cold_reg, in_data.cold_contact_low);
            // A pulse is a rising edge of the debounced state, seen as a fresh latch.
            hot_pulse  = hot_next.latched && !hot_reg.latched;
            cold_pulse = cold_next.latched && !cold_reg.latched;
            if (hot_pulse)
                hot_sum_next = hot_added;
            if (cold_pulse)
                cold_sum_next = cold_added;
        end

        out_data_next.hot_total     = hot_sum_next;
        out_data_next.cold_total    = cold_sum_next;
        out_data_next.hot_pulse     = hot_pulse;
        out_data_next.cold_pulse    = cold_pulse;
        out_data_next.hot_closed    = hot_next.closed;
        out_data_next.cold_closed   = cold_next.closed;
        out_data_next.total_wrapped = (hot_pulse && hot_wrap) || (cold_pulse && cold_wrap);
    end

    // Configuration writes; an index past the register list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lpp_reg         <= LPP_W'(1);
            hot_preset_reg  <= '0;
            cold_preset_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LITERS_PER_PULSE: lpp_reg         <= cfg_data[LPP_W-1:0];
                REG_HOT_PRESET:       hot_preset_reg  <= cfg_data[TOTAL_W-1:0];
                REG_COLD_PRESET:      cold_preset_reg <= cfg_data[TOTAL_W-1:0];
                default:              ;
            endcase
        end
    end

    // Channel state and totals advance on each accepted request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hot_reg      <= '0;
            cold_reg     <= '0;
            hot_sum_reg  <= '0;
            cold_sum_reg <= '0;
        end
        else if (in_accept)
        begin
            hot_reg      <= hot_next;
            cold_reg     <= cold_next;
            hot_sum_reg  <= hot_sum_next;
            cold_sum_reg <= cold_sum_next;
        end
    end

    // Output register: holds its result until the consumer takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            out_data_reg <= out_data_next;
    end

endmodule
